@@ rtl/md5_pkg.sv @@
// Shared types, constants and round functions for the MD5 stream hasher.
`timescale 1ns / 1ps

package md5_pkg;

    // Initial chaining vector
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [5:0] LEN_OFFSET    = 6'd56;
    localparam logic [5:0] LAST_POS      = 6'd63;

    // Datapath operation for one cycle
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_PRE,
        OP_ROUND,
        OP_ADD,
        OP_FINISH
    } t_op;

    // Kind of padding byte written
    typedef enum logic [1:0] {
        PAD_MARK,
        PAD_ZERO,
        PAD_LEN
    } t_pad;

    typedef struct packed {
        t_op        op;
        logic       wr_en;
        logic       wr_pad;
        logic [5:0] wr_addr;
        t_pad       pad_kind;
        logic       cnt_inc;
        logic [5:0] round;
        logic [5:0] rd_step;
        logic [5:0] k_step;
    } t_cmd;

    typedef struct packed {
        logic [5:0] count_lo;
        logic       out_busy;
    } t_status;

    function automatic logic [31:0] step_const(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Left-rotate amount per round group and step within the group of four
    function automatic logic [4:0] rot_amount(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
            4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
            4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
            4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Message word used by step i
    function automatic logic [3:0] msg_index(input logic [5:0] i);
        logic [3:0] g;
        case (i[5:4])
            2'd0:    g = i[3:0];
            2'd1:    g = 4'(4'd5 * i[3:0] + 4'd1);
            2'd2:    g = 4'(4'd3 * i[3:0] + 4'd5);
            default: g = 4'(4'd7 * i[3:0]);
        endcase
        return g;
    endfunction

    function automatic logic [31:0] round_fn(input logic [1:0] sel, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (sel)
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & d) | (c & ~d);
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] t;
        t = {x, x} << s;
        return t[63:32];
    endfunction

endpackage

@@ rtl/md5_dpath.sv @@
// MD5 datapath: block buffer, byte counter, chaining and working words, digest output.
`timescale 1ns / 1ps

module md5_dpath
    import md5_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_data,
    output t_status     o_status,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,
    output logic [1:0]  o_m_tuser,
    output logic        o_m_tlast
);

    logic [31:0] r_mem [16];
    logic [31:0] r_rdata;
    logic [60:0] r_count;
    logic [31:0] r_chain [4];
    logic [31:0] r_wa, r_wb, r_wc, r_wd;
    logic [31:0] r_pre;
    logic [31:0] r_out_word [4];
    logic [1:0]  r_out_idx;
    logic        r_out_busy;

    logic [5:0]  w_wr_addr;
    logic [7:0]  w_wr_byte;
    logic [63:0] w_bits;
    logic [7:0]  w_len_byte;
    logic [31:0] w_f;
    logic [31:0] w_new_b;
    logic [31:0] w_k;
    logic        w_out_take;

    assign w_bits     = {r_count, 3'b000};
    assign w_len_byte = w_bits[8 * i_cmd.wr_addr[2:0] +: 8];
    assign w_wr_addr  = i_cmd.wr_pad ? i_cmd.wr_addr : r_count[5:0];

    always_comb begin
        if (!i_cmd.wr_pad) begin
            w_wr_byte = i_data;
        end else begin
            case (i_cmd.pad_kind)
                PAD_MARK: w_wr_byte = PAD_MARK_BYTE;
                PAD_LEN:  w_wr_byte = w_len_byte;
                default:  w_wr_byte = 8'h00;
            endcase
        end
    end

    assign w_k     = step_const(i_cmd.k_step);
    assign w_f     = round_fn(i_cmd.round[5:4], r_wb, r_wc, r_wd);
    assign w_new_b = r_wb + rotl32(r_pre + w_f, rot_amount(i_cmd.round));

    // byte-lane write, one registered word read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[w_wr_addr[5:2]][8 * w_wr_addr[1:0] +: 8] <= w_wr_byte;
        end
        r_rdata <= r_mem[msg_index(i_cmd.rd_step)];
    end

    // working words and the precomputed a + K + M term
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_wa <= r_chain[0];
                r_wb <= r_chain[1];
                r_wc <= r_chain[2];
                r_wd <= r_chain[3];
            end
            OP_PRE: begin
                r_pre <= r_wa + w_k + r_rdata;
            end
            OP_ROUND: begin
                r_wa  <= r_wd;
                r_wd  <= r_wc;
                r_wc  <= r_wb;
                r_wb  <= w_new_b;
                r_pre <= r_wd + w_k + r_rdata;
            end
            OP_FINISH: begin
                r_out_word[0] <= r_chain[0] + r_wa;
                r_out_word[1] <= r_chain[1] + r_wb;
                r_out_word[2] <= r_chain[2] + r_wc;
                r_out_word[3] <= r_chain[3] + r_wd;
            end
            default: begin
            end
        endcase
    end

    assign w_out_take = r_out_busy && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain[0] <= IV_A;
            r_chain[1] <= IV_B;
            r_chain[2] <= IV_C;
            r_chain[3] <= IV_D;
            r_count    <= '0;
            r_out_busy <= 1'b0;
            r_out_idx  <= '0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + 61'd1;
            end
            if (w_out_take) begin
                r_out_idx <= r_out_idx + 2'd1;
                if (r_out_idx == 2'd3) begin
                    r_out_busy <= 1'b0;
                end
            end
            case (i_cmd.op)
                OP_ADD: begin
                    r_chain[0] <= r_chain[0] + r_wa;
                    r_chain[1] <= r_chain[1] + r_wb;
                    r_chain[2] <= r_chain[2] + r_wc;
                    r_chain[3] <= r_chain[3] + r_wd;
                end
                OP_FINISH: begin
                    r_chain[0] <= IV_A;
                    r_chain[1] <= IV_B;
                    r_chain[2] <= IV_C;
                    r_chain[3] <= IV_D;
                    r_count    <= '0;
                    r_out_busy <= 1'b1;
                    r_out_idx  <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_status.count_lo = r_count[5:0];
    assign o_status.out_busy = r_out_busy;

    assign o_m_tvalid = r_out_busy;
    assign o_m_tdata  = r_out_word[r_out_idx];
    assign o_m_tuser  = r_out_idx;
    assign o_m_tlast  = (r_out_idx == 2'd3);

    // digest words leave strictly in order A, B, C, D
    ap_out_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_take && r_out_idx != 2'd3 && i_cmd.op != OP_FINISH)
            |=> (r_out_busy && r_out_idx == $past(r_out_idx) + 2'd1))
        else $error("digest word index did not advance");

endmodule

@@ rtl/md5_ctrl.sv @@
// MD5 controller: input acceptance, padding sequencer and compression round counter.
`timescale 1ns / 1ps

module md5_ctrl
    import md5_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  logic    i_has_byte,
    input  logic    i_last_byte,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LOAD,
        S_PRE,
        S_ROUND,
        S_ADD
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_step,  n_step;
    logic [5:0] r_pos,   n_pos;
    logic       r_first, n_first;
    logic       r_len_ok, n_len_ok;
    logic       r_padding, n_padding;
    logic       r_end,   n_end;
    logic       r_final, n_final;

    logic       w_accept;
    logic [5:0] w_start;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    // padding begins after the byte of this request, if it carries one
    assign w_start    = i_has_byte ? 6'(i_status.count_lo + 6'd1) : i_status.count_lo;

    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_pos     = r_pos;
        n_first   = r_first;
        n_len_ok  = r_len_ok;
        n_padding = r_padding;
        n_end     = r_end;
        n_final   = r_final;
        o_cmd          = '0;
        o_cmd.op       = OP_NONE;
        o_cmd.pad_kind = PAD_ZERO;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_has_byte) begin
                        o_cmd.wr_en   = 1'b1;
                        o_cmd.cnt_inc = 1'b1;
                    end
                    if (i_has_byte && i_status.count_lo == LAST_POS) begin
                        n_end     = i_last_byte;
                        n_padding = 1'b0;
                        n_final   = 1'b0;
                        n_state   = S_LOAD;
                    end else if (i_last_byte) begin
                        n_pos     = w_start;
                        n_first   = 1'b1;
                        n_len_ok  = (w_start < LEN_OFFSET);
                        n_padding = 1'b1;
                        n_state   = S_PAD;
                    end
                end
            end
            S_PAD: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_pad  = 1'b1;
                o_cmd.wr_addr = r_pos;
                if (r_first) begin
                    o_cmd.pad_kind = PAD_MARK;
                end else if (r_len_ok && r_pos >= LEN_OFFSET) begin
                    o_cmd.pad_kind = PAD_LEN;
                end
                n_first = 1'b0;
                n_pos   = 6'(r_pos + 6'd1);
                if (r_pos == LAST_POS) begin
                    n_final = r_len_ok;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.op      = OP_LOAD;
                o_cmd.rd_step = 6'd0;
                n_step        = 6'd0;
                n_state       = S_PRE;
            end
            S_PRE: begin
                o_cmd.op      = OP_PRE;
                o_cmd.rd_step = 6'd1;
                o_cmd.k_step  = 6'd0;
                n_state       = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.op      = OP_ROUND;
                o_cmd.round   = r_step;
                o_cmd.rd_step = 6'(r_step + 6'd2);
                o_cmd.k_step  = 6'(r_step + 6'd1);
                n_step        = 6'(r_step + 6'd1);
                if (r_step == LAST_POS) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                if (r_final) begin
                    // hold until the previous digest has drained
                    if (!i_status.out_busy) begin
                        o_cmd.op  = OP_FINISH;
                        n_final   = 1'b0;
                        n_padding = 1'b0;
                        n_end     = 1'b0;
                        n_state   = S_IDLE;
                    end
                end else begin
                    o_cmd.op = OP_ADD;
                    if (r_padding || r_end) begin
                        n_pos     = 6'd0;
                        n_first   = !r_padding;
                        n_len_ok  = 1'b1;
                        n_padding = 1'b1;
                        n_end     = 1'b0;
                        n_state   = S_PAD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_pos     <= '0;
            r_first   <= 1'b0;
            r_len_ok  <= 1'b0;
            r_padding <= 1'b0;
            r_end     <= 1'b0;
            r_final   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_pos     <= n_pos;
            r_first   <= n_first;
            r_len_ok  <= n_len_ok;
            r_padding <= n_padding;
            r_end     <= n_end;
            r_final   <= n_final;
        end
    end

    ap_rounds_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_step == LAST_POS) |=> (r_state == S_ADD))
        else $error("compression did not end after the last round");

    ap_rounds_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_ROUND) |-> (r_step == 6'd0 && $past(r_state == S_PRE)))
        else $error("rounds entered without preload");

    ap_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_FINISH) |-> !i_status.out_busy)
        else $error("digest overwritten before it was taken");

endmodule

@@ rtl/md5_byte_stream_hasher.sv @@
// Top level of the MD5 byte stream hasher: controller plus datapath.
//
//  channel  | dir | tdata                 | tuser          | tlast
//  ---------+-----+-----------------------+----------------+-----------
//  s (in)   | in  | [7:0] data_byte       | [0] has_byte   | last_byte
//  m (out)  | out | [31:0] digest_word    | [1:0] word_idx | last_word
//
// A byte request is accepted only while idle; one that fills the 64-byte block
// adds a compression (load, preload, 64 rounds, add) before the next is taken.
// The last request adds a padding write per byte from the marker to the block
// end and a compression; a marker at offset 56 or later adds a second padded
// block and compression. Reset (synchronous) loads the initial vector, clears
// the count and the output valid and index. A second digest waits for the first.
`timescale 1ns / 1ps

module md5_byte_stream_hasher
    import md5_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] has_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [1:0]  m_tuser,   // [1:0] word_index
    output logic        m_tlast    // last_word
);

    t_cmd    w_cmd;
    t_status w_status;

    md5_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_has_byte  (s_tuser),
        .i_last_byte (s_tlast),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    md5_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_data     (s_tdata),
        .o_status   (w_status),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

endmodule
